/* rtl/core/clifford_tableau_gate_append_assert.svh */
// Assertion macros for the tableau block checkers.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CLIFFORD_TABLEAU_GATE_APPEND_ASSERT_SVH
`define CLIFFORD_TABLEAU_GATE_APPEND_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CTGA_AST_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tableau check failed");

// next-cycle implication, disabled while reset is held
`define CTGA_AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tableau check failed");

`endif

/* rtl/core/ctga_pkg.sv */
// Shared types and constants of the tableau gate-append block:
// opcodes, micro-op encoding, microprogram ROM and dispatch table. No dependencies.
package ctga_pkg;

  typedef enum logic [3:0] {
    OP_X     = 4'd0,
    OP_Z     = 4'd1,
    OP_V     = 4'd2,
    OP_S     = 4'd3,
    OP_H     = 4'd4,
    OP_CX    = 4'd5,
    OP_CZ    = 4'd6,
    OP_READ  = 4'd7,
    OP_RESET = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_RD,
    U_LD,
    U_X,
    U_Z,
    U_V,
    U_S,
    U_CX,
    U_WRA,
    U_WRB,
    U_INIT,
    U_RPT
  } uop_t;

  typedef enum logic [1:0] {
    J_SEQ,
    J_GOTO,
    J_DISP,
    J_END
  } jmp_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t op;
    logic sel_b;
    jmp_t jmp;
    upc_t target;
  } ctl_word_t;

  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // microprogram addresses
  localparam upc_t UA_RD   = 5'd0;
  localparam upc_t UA_LD   = 5'd1;
  localparam upc_t UA_X    = 5'd2;
  localparam upc_t UA_Z    = 5'd3;
  localparam upc_t UA_V    = 5'd4;
  localparam upc_t UA_S    = 5'd5;
  localparam upc_t UA_H    = 5'd6;
  localparam upc_t UA_H1   = 5'd7;
  localparam upc_t UA_H2   = 5'd8;
  localparam upc_t UA_CX   = 5'd9;
  localparam upc_t UA_CZ   = 5'd10;
  localparam upc_t UA_CZ1  = 5'd11;
  localparam upc_t UA_CZ2  = 5'd12;
  localparam upc_t UA_CZ3  = 5'd13;
  localparam upc_t UA_CZ4  = 5'd14;
  localparam upc_t UA_CZ5  = 5'd15;
  localparam upc_t UA_WRB  = 5'd16;
  localparam upc_t UA_WRA  = 5'd17;
  localparam upc_t UA_INIT = 5'd18;
  localparam upc_t UA_RPT  = 5'd19;

  localparam ctl_word_t CW_IDLE = '{op: U_NOP, sel_b: SEL_A, jmp: J_END, target: UA_RD};

  function automatic ctl_word_t mk_cw(uop_t op, logic sel_b, jmp_t jmp, upc_t target);
    ctl_word_t w;
    w.op     = op;
    w.sel_b  = sel_b;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic ctl_word_t ucode(upc_t pc);
    ctl_word_t w;
    case (pc)
      UA_RD:   w = mk_cw(U_RD,   SEL_A, J_SEQ,  UA_RD);
      UA_LD:   w = mk_cw(U_LD,   SEL_A, J_DISP, UA_RD);
      UA_X:    w = mk_cw(U_X,    SEL_A, J_GOTO, UA_WRA);
      UA_Z:    w = mk_cw(U_Z,    SEL_A, J_GOTO, UA_WRA);
      UA_V:    w = mk_cw(U_V,    SEL_A, J_GOTO, UA_WRA);
      UA_S:    w = mk_cw(U_S,    SEL_A, J_GOTO, UA_WRA);
      UA_H:    w = mk_cw(U_S,    SEL_A, J_SEQ,  UA_RD);
      UA_H1:   w = mk_cw(U_V,    SEL_A, J_SEQ,  UA_RD);
      UA_H2:   w = mk_cw(U_S,    SEL_A, J_GOTO, UA_WRA);
      UA_CX:   w = mk_cw(U_CX,   SEL_A, J_GOTO, UA_WRB);
      UA_CZ:   w = mk_cw(U_S,    SEL_A, J_SEQ,  UA_RD);
      UA_CZ1:  w = mk_cw(U_S,    SEL_B, J_SEQ,  UA_RD);
      UA_CZ2:  w = mk_cw(U_CX,   SEL_A, J_SEQ,  UA_RD);
      UA_CZ3:  w = mk_cw(U_S,    SEL_B, J_SEQ,  UA_RD);
      UA_CZ4:  w = mk_cw(U_Z,    SEL_B, J_SEQ,  UA_RD);
      UA_CZ5:  w = mk_cw(U_CX,   SEL_A, J_GOTO, UA_WRB);
      UA_WRB:  w = mk_cw(U_WRB,  SEL_B, J_SEQ,  UA_RD);
      UA_WRA:  w = mk_cw(U_WRA,  SEL_A, J_GOTO, UA_RPT);
      UA_INIT: w = mk_cw(U_INIT, SEL_A, J_SEQ,  UA_RD);
      UA_RPT:  w = mk_cw(U_RPT,  SEL_A, J_END,  UA_RD);
      default: w = CW_IDLE;
    endcase
    return w;
  endfunction

  // Entry point after the rows are loaded.
  function automatic upc_t dispatch(op_t op, logic reject);
    upc_t pc;
    if (reject) begin
      pc = UA_RPT;
    end else begin
      case (op)
        OP_X:     pc = UA_X;
        OP_Z:     pc = UA_Z;
        OP_V:     pc = UA_V;
        OP_S:     pc = UA_S;
        OP_H:     pc = UA_H;
        OP_CX:    pc = UA_CX;
        OP_CZ:    pc = UA_CZ;
        OP_RESET: pc = UA_INIT;
        default:  pc = UA_RPT;
      endcase
    end
    return pc;
  endfunction

endpackage

/* rtl/core/ctga_useq.sv */
// Microcode sequencer: step counter, control-store fetch and jumps.
// Depends on ctga_pkg.
module ctga_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [3:0]          opcode,
  input  logic                a_ok,
  input  logic                b_ok,
  input  logic                same,
  output logic                busy,
  output logic                reject,
  output ctga_pkg::ctl_word_t cw
);
  import ctga_pkg::*;

  logic      busy_r, busy_nxt;
  upc_t      pc_r, pc_nxt;
  op_t       op_r, op_nxt;
  logic      reject_r, reject_nxt;
  op_t       op_in;
  logic      rej_in;
  ctl_word_t cw_rom;

  assign op_in  = op_t'(opcode);
  assign cw_rom = ucode(pc_r);

  always_comb begin
    case (op_in)
      OP_X, OP_Z, OP_V, OP_S, OP_H: rej_in = !a_ok;
      OP_CX, OP_CZ:                 rej_in = !a_ok || !b_ok || same;
      OP_RESET:                     rej_in = 1'b0;
      default:                      rej_in = !a_ok;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    pc_nxt     = pc_r;
    op_nxt     = op_r;
    reject_nxt = reject_r;
    if (start && !busy_r) begin
      busy_nxt   = 1'b1;
      pc_nxt     = UA_RD;
      op_nxt     = op_in;
      reject_nxt = rej_in;
    end else if (busy_r) begin
      case (cw_rom.jmp)
        J_SEQ:   pc_nxt = upc_t'(pc_r + 1'b1);
        J_GOTO:  pc_nxt = cw_rom.target;
        J_DISP:  pc_nxt = dispatch(op_r, reject_r);
        J_END:   busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= UA_RD;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    reject_r <= reject_nxt;
  end

  assign busy   = busy_r;
  assign reject = reject_r;
  assign cw     = busy_r ? cw_rom : CW_IDLE;

endmodule

/* rtl/core/ctga_dp.sv */
// Tableau datapath: row memories with valid bits, working rows of both
// qubits, sign word, row-update logic and result registers. Depends on ctga_pkg.
module ctga_dp #(
  parameter int QUBITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [3:0]          qubit_a,
  input  logic [3:0]          qubit_b,
  input  logic                a_ok,
  input  logic                reject,
  input  ctga_pkg::ctl_word_t cw,
  output logic                out_valid,
  output logic [31:0]         z_row_out,
  output logic [31:0]         x_row_out,
  output logic [31:0]         sign_word,
  output logic                error_flag
);
  import ctga_pkg::*;

  localparam int QW = (QUBITS > 1) ? $clog2(QUBITS) : 1;
  localparam int W  = 2 * QUBITS;

  logic [W-1:0] z_mem [QUBITS];
  logic [W-1:0] x_mem [QUBITS];

  logic [QUBITS-1:0] vld_r, vld_nxt;
  logic [QW-1:0]     a_idx_r, b_idx_r;
  logic              a_ok_r;

  logic [W-1:0] z_rda_r, z_rdb_r, x_rda_r, x_rdb_r;
  logic         hit_a_r, hit_b_r;

  logic [W-1:0] za_r, za_nxt, xa_r, xa_nxt, zb_r, zb_nxt, xb_r, xb_nxt;
  logic [W-1:0] sign_r, sign_nxt;
  logic [W-1:0] zs, xs, zs_new, xs_new;
  logic [W-1:0] zrst_a, xrst_a, zrst_b, xrst_b;

  logic          wr_en;
  logic [QW-1:0] wr_idx;
  logic [W-1:0]  wr_z, wr_x;

  logic [W+31:0] za_ext, xa_ext, sign_ext;

  logic        out_valid_r;
  logic [31:0] z_out_r, x_out_r, sign_out_r;
  logic        err_out_r;

  // identity rows of the selected qubits
  assign zrst_a = W'(1) << a_idx_r;
  assign xrst_a = W'(1) << (a_idx_r + QUBITS);
  assign zrst_b = W'(1) << b_idx_r;
  assign xrst_b = W'(1) << (b_idx_r + QUBITS);

  always_ff @(posedge clk) begin
    if (load) begin
      a_idx_r <= QW'(qubit_a);
      b_idx_r <= QW'(qubit_b);
      a_ok_r  <= a_ok;
    end
  end

  // registered reads, two addresses per array
  always_ff @(posedge clk) begin
    if (cw.op == U_RD) begin
      z_rda_r <= z_mem[a_idx_r];
      z_rdb_r <= z_mem[b_idx_r];
      x_rda_r <= x_mem[a_idx_r];
      x_rdb_r <= x_mem[b_idx_r];
      hit_a_r <= vld_r[a_idx_r];
      hit_b_r <= vld_r[b_idx_r];
    end
  end

  assign zs = cw.sel_b ? zb_r : za_r;
  assign xs = cw.sel_b ? xb_r : xa_r;

  always_comb begin
    za_nxt   = za_r;
    xa_nxt   = xa_r;
    zb_nxt   = zb_r;
    xb_nxt   = xb_r;
    sign_nxt = sign_r;
    zs_new   = zs;
    xs_new   = xs;
    case (cw.op)
      U_LD: begin
        za_nxt = hit_a_r ? z_rda_r : zrst_a;
        xa_nxt = hit_a_r ? x_rda_r : xrst_a;
        zb_nxt = hit_b_r ? z_rdb_r : zrst_b;
        xb_nxt = hit_b_r ? x_rdb_r : xrst_b;
      end
      U_X: sign_nxt = sign_r ^ zs;
      U_Z: sign_nxt = sign_r ^ xs;
      U_V: begin
        sign_nxt = sign_r ^ (~xs & zs);
        xs_new   = xs ^ zs;
      end
      U_S: begin
        sign_nxt = sign_r ^ (zs & xs);
        zs_new   = zs ^ xs;
      end
      U_CX: begin
        sign_nxt = sign_r ^ ((~za_r ^ xb_r) & zb_r & xa_r);
        za_nxt   = za_r ^ zb_r;
        xb_nxt   = xb_r ^ xa_r;
      end
      U_INIT: begin
        sign_nxt = '0;
        za_nxt   = zrst_a;
        xa_nxt   = xrst_a;
      end
      default: ;
    endcase
    // single-qubit ops write back into the selected working pair
    if (cw.op == U_V || cw.op == U_S) begin
      if (cw.sel_b) begin
        zb_nxt = zs_new;
        xb_nxt = xs_new;
      end else begin
        za_nxt = zs_new;
        xa_nxt = xs_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    za_r <= za_nxt;
    xa_r <= xa_nxt;
    zb_r <= zb_nxt;
    xb_r <= xb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r <= '0;
    end else begin
      sign_r <= sign_nxt;
    end
  end

  // one write port per array
  always_comb begin
    wr_en  = (cw.op == U_WRA) || (cw.op == U_WRB);
    wr_idx = (cw.op == U_WRB) ? b_idx_r : a_idx_r;
    wr_z   = (cw.op == U_WRB) ? zb_r : za_r;
    wr_x   = (cw.op == U_WRB) ? xb_r : xa_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      z_mem[wr_idx] <= wr_z;
      x_mem[wr_idx] <= wr_x;
    end
  end

  // an entry without its valid bit reads as the identity row
  always_comb begin
    vld_nxt = vld_r;
    case (cw.op)
      U_WRA, U_WRB: vld_nxt[wr_idx] = 1'b1;
      U_INIT:       vld_nxt = '0;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign za_ext   = {32'd0, za_r};
  assign xa_ext   = {32'd0, xa_r};
  assign sign_ext = {32'd0, sign_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cw.op == U_RPT);
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == U_RPT) begin
      z_out_r    <= a_ok_r ? za_ext[31:0] : 32'd0;
      x_out_r    <= a_ok_r ? xa_ext[31:0] : 32'd0;
      sign_out_r <= sign_ext[31:0];
      err_out_r  <= reject;
    end
  end

  assign out_valid  = out_valid_r;
  assign z_row_out  = z_out_r;
  assign x_row_out  = x_out_r;
  assign sign_word  = sign_out_r;
  assign error_flag = err_out_r;

endmodule

/* rtl/core/clifford_tableau_gate_append.sv */
// Clifford tableau gate append. The busy time of each transaction is set by the
// microprogram, which reads, updates and writes back the working rows step by step.
// out_valid pulses at the edge that clears busy; a new start is taken only while busy
// is low. The receiver cannot stall.
// Synchronous reset (rst_n low) restores the identity tableau at once via row valid
// bits and clears the signs; no clearing pass.
module clifford_tableau_gate_append #(
  parameter int QUBITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [3:0]  in_opcode,
  input  logic [3:0]  in_qubit_a,
  input  logic [3:0]  in_qubit_b,
  output logic        busy,
  output logic        out_valid,
  output logic [31:0] out_z_row_out,
  output logic [31:0] out_x_row_out,
  output logic [31:0] out_sign_word,
  output logic        out_error_flag
);
  import ctga_pkg::*;

  localparam logic [5:0] QLIM = 6'(QUBITS);

  logic      a_ok, b_ok, same, reject, accept;
  ctl_word_t cw;

  assign a_ok   = {2'b00, in_qubit_a} < QLIM;
  assign b_ok   = {2'b00, in_qubit_b} < QLIM;
  assign same   = (in_qubit_a == in_qubit_b);
  assign accept = start && !busy;

  ctga_useq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .a_ok   (a_ok),
    .b_ok   (b_ok),
    .same   (same),
    .busy   (busy),
    .reject (reject),
    .cw     (cw)
  );

  ctga_dp #(
    .QUBITS (QUBITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .qubit_a    (in_qubit_a),
    .qubit_b    (in_qubit_b),
    .a_ok       (a_ok),
    .reject     (reject),
    .cw         (cw),
    .out_valid  (out_valid),
    .z_row_out  (out_z_row_out),
    .x_row_out  (out_x_row_out),
    .sign_word  (out_sign_word),
    .error_flag (out_error_flag)
  );

endmodule

/* rtl/core/ctga_chk.sv */
// Port-level checker for the tableau block, bound to the top level.
// Depends on clifford_tableau_gate_append_assert.svh.
module ctga_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
`include "clifford_tableau_gate_append_assert.svh"

  // a taken transaction keeps the block busy
  `CTGA_AST_NXT(a_accept_busy, start && !busy, busy)
  // the result strobe is a single-cycle pulse
  `CTGA_AST_NXT(a_strobe_pulse, out_valid, !out_valid)
  // finishing a transaction always reports it
  `CTGA_AST_IMP(a_done_reports, $fell(busy), out_valid)
  // a result is shown only after the work is done
  `CTGA_AST_IMP(a_result_idle, out_valid, !busy && $fell(busy))

endmodule

bind clifford_tableau_gate_append ctga_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
